[hw/rtl/sequential_list_engine_core_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the list engine
// Shared concurrent assertion forms, clocked and disabled by reset.
// ---------------------------------------------------------------------------
`ifndef SEQUENTIAL_LIST_ENGINE_CORE_ASSERT_SVH
`define SEQUENTIAL_LIST_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication
`define SLE_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define SLE_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/sle_pkg.sv]
// ---------------------------------------------------------------------------
// sle_pkg
// Types, codes and constants shared by the list engine modules.
// ---------------------------------------------------------------------------
package sle_pkg;

   localparam int SLE_DEPTH      = 64;
   localparam int SLE_DATA_WIDTH = 32;
   localparam int SCAN_LANES     = 8;

   localparam int REQ_TYPE_W    = 3;
   localparam int POSITION_W    = 7;
   localparam int VALUE_W       = 32;
   localparam int STATUS_W      = 2;
   localparam int FOUND_INDEX_W = 6;
   localparam int COUNT_W       = 7;

   typedef enum logic [REQ_TYPE_W-1:0] {
      OP_PUSH_BACK  = 3'd0,
      OP_PUSH_FRONT = 3'd1,
      OP_POP_BACK   = 3'd2,
      OP_POP_FRONT  = 3'd3,
      OP_INSERT     = 3'd4,
      OP_ERASE      = 3'd5,
      OP_FIND       = 3'd6
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 2'd0,
      ST_FULL   = 2'd1,
      ST_EMPTY  = 2'd2,
      ST_BADPOS = 2'd3
   } status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_SCAN = 1'b1
   } state_type;

   typedef struct packed {
      logic [REQ_TYPE_W-1:0]    req_type;
      logic [POSITION_W-1:0]    position;
      logic signed [VALUE_W-1:0] value;
   } sle_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic                     found;
      logic [FOUND_INDEX_W-1:0] found_index;
      logic [COUNT_W-1:0]       count;
   } sle_rsp_type;

   // Per-cycle command broadcast to every cell
   typedef struct packed {
      logic insert;
      logic erase;
      logic find;
   } cell_op_type;

   // Scan unit status towards the control
   typedef struct packed {
      logic done;
      logic hit;
   } scan_stat_type;

endpackage

[hw/rtl/sle_cell.sv]
// ---------------------------------------------------------------------------
// sle_cell
// One list slot: holds an entry, shifts with its neighbours, flags a match.
// ---------------------------------------------------------------------------
module sle_cell import sle_pkg::*; #(
   parameter int INDEX      = 0,
   parameter int DATA_WIDTH = SLE_DATA_WIDTH,
   parameter int PW         = POSITION_W
) (
   input  logic                  clock,
   input  cell_op_type           op,
   input  logic [PW-1:0]         pos,
   input  logic [PW-1:0]         count,
   input  logic [DATA_WIDTH-1:0] word,
   input  logic [DATA_WIDTH-1:0] left_data,
   input  logic [DATA_WIDTH-1:0] right_data,
   output logic [DATA_WIDTH-1:0] data,
   output logic                  match
);

   localparam logic [PW-1:0] IDX = PW'(INDEX);

   logic [DATA_WIDTH-1:0] data_ff, data_in;
   logic                  match_ff, match_in;

   always_comb begin
      data_in  = data_ff;
      match_in = match_ff;
      if (op.insert) begin
         if (IDX == pos) begin
            data_in = word;
         end else if (IDX > pos) begin
            data_in = left_data;
         end
      end else if (op.erase && (IDX >= pos)) begin
         data_in = right_data;
      end
      if (op.find) begin
         match_in = (data_ff == word) && (IDX < count);
      end
   end

   always_ff @(posedge clock) begin
      data_ff  <= data_in;
      match_ff <= match_in;
   end

   assign data  = data_ff;
   assign match = match_ff;

endmodule

[hw/rtl/sle_scan.sv]
// ---------------------------------------------------------------------------
// sle_scan
// First-match search over the cell match flags, one lane group per cycle.
// ---------------------------------------------------------------------------
module sle_scan import sle_pkg::*; #(
   parameter int DEPTH = SLE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       hold,
   input  logic [DEPTH-1:0]           match,
   output scan_stat_type              stat,
   output logic [$clog2(DEPTH)-1:0]   index
);

   localparam int IW     = $clog2(DEPTH);
   localparam int LW     = $clog2(SCAN_LANES);
   localparam int GROUPS = (DEPTH + SCAN_LANES - 1) / SCAN_LANES;
   localparam int GW     = (GROUPS > 1) ? $clog2(GROUPS) : 1;
   localparam int PADW   = GROUPS * SCAN_LANES;

   logic                  active_ff, active_in;
   logic [GW-1:0]         group_ff, group_in;
   logic [PADW-1:0]       padded;
   logic [SCAN_LANES-1:0] slice;
   logic                  lane_hit;
   logic [LW-1:0]         lane;
   logic                  last;
   logic                  done;

   assign padded = PADW'(match);
   assign slice  = padded[group_ff*SCAN_LANES +: SCAN_LANES];
   assign last   = (group_ff == GW'(GROUPS - 1));

   // Lowest set lane wins
   always_comb begin
      lane_hit = 1'b0;
      lane     = '0;
      for (int k = SCAN_LANES - 1; k >= 0; k--) begin
         if (slice[k]) begin
            lane_hit = 1'b1;
            lane     = LW'(k);
         end
      end
   end

   assign done = active_ff && (lane_hit || last);

   always_comb begin
      active_in = active_ff;
      group_in  = group_ff;
      if (start) begin
         active_in = 1'b1;
         group_in  = '0;
      end else if (done) begin
         if (!hold) begin
            active_in = 1'b0;
         end
      end else if (active_ff) begin
         group_in = group_ff + GW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         group_ff  <= '0;
      end else begin
         active_ff <= active_in;
         group_ff  <= group_in;
      end
   end

   assign stat.done = done;
   assign stat.hit  = lane_hit;
   assign index     = lane_hit ? IW'({group_ff, lane}) : '0;

endmodule

[hw/rtl/sequential_list_engine_core.sv]
// ---------------------------------------------------------------------------
// sequential_list_engine_core
// Ordered list of signed words kept in a row of shifting cells.
//
// Usage: present a request item on req_data with req_valid; it is taken at
// a rising edge where req_stall is low. Each item is one of push back, push
// front, pop back, pop front, insert, erase or find, and yields exactly one
// response item on rsp_data, taken when rsp_valid is high and rsp_stall low.
// Every operation other than find updates the cells at the accept edge and
// registers its response into output slot 0, or slot 1 if slot 0 is held; a
// new item can follow in the next cycle, so these run at one item per cycle
// while req_stall stays low. Find registers a compare flag in every cell at
// the accept edge, then the scan unit walks the flags eight lanes a cycle,
// stopping at the first hit; input stays stalled until the response is made.
// Reset empties the list (count zero); no clearing pass runs, cell contents
// are simply ignored beyond the count. A two-deep output buffer lets the
// engine take one more item while a response is held by a stalled receiver;
// with both slots full req_stall rises until the receiver drains one.
// ---------------------------------------------------------------------------
`include "sequential_list_engine_core_assert.svh"

module sequential_list_engine_core import sle_pkg::*; #(
   parameter int DEPTH      = SLE_DEPTH,
   parameter int DATA_WIDTH = SLE_DATA_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  sle_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output sle_rsp_type rsp_data
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IW    = $clog2(DEPTH);
   // compare width wide enough for both the position field and the count
   localparam int PW    = (CNT_W > POSITION_W) ? CNT_W : POSITION_W;

   // ------------------------------------------------------------------
   // Control state
   // ------------------------------------------------------------------
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   // output buffer: slot 0 drives the port, slot 1 catches overflow
   logic               out0_vld_ff, out0_vld_in;
   logic               out1_vld_ff, out1_vld_in;
   sle_rsp_type        out0_ff, out0_in;
   sle_rsp_type        out1_ff, out1_in;

   logic               accept;
   logic               take;
   logic               produce;
   sle_rsp_type        result;

   // decode
   logic [PW-1:0]      pos_x;
   logic [PW-1:0]      cnt_x;
   logic [PW-1:0]      eff_pos;
   logic               full;
   logic               empty;
   logic               do_ins;
   logic               do_ers;
   logic               do_dec;
   logic               do_find;
   status_type         status;
   logic [63:0]        value_sx;
   logic [DATA_WIDTH-1:0] word;

   // cell row
   cell_op_type        cell_op;
   logic [DATA_WIDTH-1:0] cell_data [DEPTH];
   logic [DEPTH-1:0]   cell_match;

   // scan
   scan_stat_type      scan_stat;
   logic [IW-1:0]      scan_index;
   logic               scan_finish;

   assign accept = req_valid && !req_stall;
   assign take   = out0_vld_ff && !rsp_stall;

   // Hold input while searching or while both response slots are taken
   assign req_stall = (state_ff != S_IDLE) || out1_vld_ff;

   // Sign-extend the key, then keep DATA_WIDTH bits
   assign value_sx = {{(64 - VALUE_W){req_data.value[VALUE_W-1]}}, req_data.value};
   assign word     = value_sx[DATA_WIDTH-1:0];

   // ------------------------------------------------------------------
   // Request decode: status and the cell command
   // ------------------------------------------------------------------
   assign pos_x = PW'(req_data.position);
   assign cnt_x = PW'(count_ff);
   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);

   always_comb begin
      status  = ST_OK;
      do_ins  = 1'b0;
      do_ers  = 1'b0;
      do_dec  = 1'b0;
      do_find = 1'b0;
      eff_pos = pos_x;
      case (op_type'(req_data.req_type))
         OP_PUSH_BACK: begin
            eff_pos = cnt_x;
            if (full) status = ST_FULL;
            else do_ins = 1'b1;
         end
         OP_PUSH_FRONT: begin
            eff_pos = '0;
            if (full) status = ST_FULL;
            else do_ins = 1'b1;
         end
         OP_POP_BACK: begin
            if (empty) status = ST_EMPTY;
            else do_dec = 1'b1;
         end
         OP_POP_FRONT: begin
            eff_pos = '0;
            if (empty) status = ST_EMPTY;
            else do_ers = 1'b1;
         end
         OP_INSERT: begin
            // a bad position outranks a full list
            if (pos_x > cnt_x) status = ST_BADPOS;
            else if (full) status = ST_FULL;
            else do_ins = 1'b1;
         end
         OP_ERASE: begin
            if (pos_x >= cnt_x) status = ST_BADPOS;
            else do_ers = 1'b1;
         end
         OP_FIND: begin
            do_find = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Drive the cells only on an accepted item
   assign cell_op.insert = accept && do_ins;
   assign cell_op.erase  = accept && do_ers;
   assign cell_op.find   = accept && do_find;

   always_comb begin
      count_in = count_ff;
      if (accept && do_ins) begin
         count_in = count_ff + CNT_W'(1);
      end else if (accept && (do_ers || do_dec)) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // ------------------------------------------------------------------
   // Cell row: each cell takes from its left neighbour on insert and from
   // its right neighbour on erase
   // ------------------------------------------------------------------
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_data;
      logic [DATA_WIDTH-1:0] right_data;

      if (i == 0) begin : g_head
         assign left_data = word;
      end else begin : g_body
         assign left_data = cell_data[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_data = '0;
      end else begin : g_mid
         assign right_data = cell_data[i+1];
      end

      sle_cell #(
         .INDEX      (i),
         .DATA_WIDTH (DATA_WIDTH),
         .PW         (PW)
      ) u_cell (
         .clock      (clock),
         .op         (cell_op),
         .pos        (eff_pos),
         .count      (cnt_x),
         .word       (word),
         .left_data  (left_data),
         .right_data (right_data),
         .data       (cell_data[i]),
         .match      (cell_match[i])
      );
   end

   // ------------------------------------------------------------------
   // First-match scan over the registered flags
   // ------------------------------------------------------------------
   sle_scan #(
      .DEPTH (DEPTH)
   ) u_scan (
      .clock (clock),
      .reset (reset),
      .start (cell_op.find),
      .hold  (out1_vld_ff),
      .match (cell_match),
      .stat  (scan_stat),
      .index (scan_index)
   );

   assign scan_finish = (state_ff == S_SCAN) && scan_stat.done && !out1_vld_ff;

   // ------------------------------------------------------------------
   // State machine: next state
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && do_find) state_in = S_SCAN;
         end
         S_SCAN: begin
            if (scan_finish) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // State machine: response item
   // ------------------------------------------------------------------
   always_comb begin
      produce            = 1'b0;
      result.status      = ST_OK;
      result.found       = 1'b0;
      result.found_index = '0;
      result.count       = COUNT_W'(count_ff);
      case (state_ff)
         S_IDLE: begin
            produce       = accept && !do_find;
            result.status = status;
            result.count  = COUNT_W'(count_in);
         end
         S_SCAN: begin
            produce            = scan_finish;
            result.found       = scan_stat.hit;
            result.found_index = FOUND_INDEX_W'(scan_index);
         end
         default: begin
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Output buffer; advance slot 1 into slot 0 as slot 0 drains
   // ------------------------------------------------------------------
   always_comb begin
      out0_vld_in = out0_vld_ff;
      out0_in     = out0_ff;
      out1_vld_in = out1_vld_ff;
      out1_in     = out1_ff;
      if (!out0_vld_ff || take) begin
         if (out1_vld_ff) begin
            out0_vld_in = 1'b1;
            out0_in     = out1_ff;
            out1_vld_in = 1'b0;
         end else if (produce) begin
            out0_vld_in = 1'b1;
            out0_in     = result;
         end else begin
            out0_vld_in = 1'b0;
         end
      end else if (produce) begin
         out1_vld_in = 1'b1;
         out1_in     = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         count_ff    <= '0;
         out0_vld_ff <= 1'b0;
         out1_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         out0_vld_ff <= out0_vld_in;
         out1_vld_ff <= out1_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out0_ff <= out0_in;
      out1_ff <= out1_in;
   end

   assign rsp_valid = out0_vld_ff;
   assign rsp_data  = out0_ff;

   // ------------------------------------------------------------------
   // Checks
   // ------------------------------------------------------------------
   `SLE_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH), "count above depth")
   `SLE_ASSERT_NOW(a_buffer_order, clock, reset, out1_vld_ff, out0_vld_ff, "slot 1 full with slot 0 empty")
   `SLE_ASSERT_NOW(a_scan_blocks, clock, reset, state_ff == S_SCAN, req_stall, "item taken during search")
   `SLE_ASSERT_NEXT(a_resp_follows, clock, reset, accept && !do_find, out0_vld_ff, "no response after item")

endmodule
